>>> sv/wep_pkg.sv
// Shared types and constants for the wavetable envelope player.
// Holds the action and phase codes, controller states and the command and
// status structs between the controller and the datapath. No dependencies.
package wep_pkg;

  // Field and register widths.
  localparam int LEN_W     = 24;
  localparam int VAL_W     = 16;
  localparam int ACT_W     = 2;
  localparam int ADDR_W    = 9;
  localparam int CFG_IDX_W = 2;

  // Shared divider: remainder width covers a divisor of twice a phase length.
  localparam int DIVR_W = LEN_W + 1;
  // Quotient bits of the rounding division, which is biased to stay positive.
  localparam int IQ_W   = 18;
  localparam int DCNT_W = 5;

  // Interpolation datapath widths.
  localparam int DIFF_W = VAL_W + 1;
  localparam int P2_W   = DIFF_W + LEN_W + 1;
  localparam int N2_W   = P2_W + 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK,
    ACT_TRIGGER,
    ACT_WRITE,
    ACT_READY
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ATTACK,
    PH_MIDDLE,
    PH_RELEASE
  } phase_t;

  // What the current request turns out to be once it is decoded.
  typedef enum logic [1:0] {
    TK_NONE,
    TK_IDLE,
    TK_END,
    TK_INTERP
  } tick_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RDEND,
    S_D1LOAD,
    S_D1RUN,
    S_RD1,
    S_RD2,
    S_MUL,
    S_D2LOAD,
    S_D2RUN,
    S_FIN,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic end_cap;
    logic div1_load;
    logic div2_load;
    logic div_step;
    logic rd1;
    logic rd2;
    logic mul;
    logic fin;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    tick_kind_t kind;
    logic       div_busy;
  } dp_status_t;

endpackage

>>> sv/wavetable_envelope_player_top.sv
// Wavetable envelope player: plays an attack, middle and release envelope
// from a table of signed Q2.14 entries.
//
// Input channel (in_valid / in_stall): each request carries an action:
// sample tick, trigger, table write or mark ready. Only a sample tick
// gives a result. Output channel (out_valid / out_stall) carries the
// envelope sample and the phase after the tick. Lengths are set through
// the write port (cfg_we, cfg_index, cfg_data); the user must write them
// only while the block is idle, which the block itself does not enforce.
// One request is worked on at a time. An interpolating tick runs the
// shared restoring divider one quotient bit a cycle, first for the table
// position, then 18 bits for the rounded step, with two reads of the
// single table read port in between.
// The result register lets the next request be taken while a result waits.
// If the receiver stalls and a new result is ready, the block holds in its
// output state and stops taking requests until the register frees.
// Reset clears phase, count, ready flag and lengths; the table itself
// is not cleared and must be written before it is read.
// Depends on wep_pkg, wep_ctrl, wep_datapath and wep_ram.
module wavetable_envelope_player_top #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [wep_pkg::ACT_W-1:0]             action,
  input  logic [wep_pkg::ADDR_W-1:0]            entry_address,
  input  logic signed [wep_pkg::VAL_W-1:0]      entry_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [wep_pkg::VAL_W-1:0]      envelope_value,
  output logic [1:0]                            phase_now,
  input  logic                                  cfg_we,
  input  logic [wep_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wep_pkg::LEN_W-1:0]             cfg_data
);
  import wep_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  wep_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic, state and table.
  wep_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .action        (action),
    .entry_address (entry_address),
    .entry_value   (entry_value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .envelope_value(envelope_value),
    .phase_now     (phase_now)
  );

endmodule

>>> sv/wep_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the envelope table. No dependencies.
module wep_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/wep_ctrl.sv
// Controller state machine for the wavetable envelope player.
// Sequences decode, division, table reads and output; depends on wep_pkg.
module wep_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  wep_pkg::dp_status_t status,
  output wep_pkg::dp_cmd_t    cmd
);
  import wep_pkg::*;

  ctrl_state_t state, state_next;

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and datapath commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (status.kind)
          TK_IDLE:   state_next = S_OUT;
          TK_END:    state_next = S_RDEND;
          TK_INTERP: state_next = S_D1LOAD;
          default:   state_next = S_IDLE;
        endcase
      end
      S_RDEND: begin
        cmd.end_cap = 1'b1;
        state_next  = S_OUT;
      end
      S_D1LOAD: begin
        cmd.div1_load = 1'b1;
        state_next    = S_D1RUN;
      end
      S_D1RUN: begin
        if (status.div_busy) begin
          cmd.div_step = 1'b1;
        end else begin
          state_next = S_RD1;
        end
      end
      S_RD1: begin
        cmd.rd1    = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.rd2    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_D2LOAD;
      end
      S_D2LOAD: begin
        cmd.div2_load = 1'b1;
        state_next    = S_D2RUN;
      end
      S_D2RUN: begin
        if (status.div_busy) begin
          cmd.div_step = 1'b1;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> sv/wep_datapath.sv
// Datapath of the wavetable envelope player: configuration, phase state,
// the envelope table, a shared restoring divider and interpolation.
// Depends on wep_pkg and wep_ram.
module wep_datapath #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  wep_pkg::dp_cmd_t                      cmd,
  output wep_pkg::dp_status_t                   status,
  input  logic [wep_pkg::ACT_W-1:0]             action,
  input  logic [wep_pkg::ADDR_W-1:0]            entry_address,
  input  logic signed [wep_pkg::VAL_W-1:0]      entry_value,
  input  logic                                  cfg_we,
  input  logic [wep_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wep_pkg::LEN_W-1:0]             cfg_data,
  output logic signed [wep_pkg::VAL_W-1:0]      envelope_value,
  output logic [1:0]                            phase_now
);
  import wep_pkg::*;

  localparam int AW         = $clog2(TABLE_DEPTH);
  localparam int ATT_SIZE   = TABLE_DEPTH / 4;
  localparam int MID_START  = ATT_SIZE;
  localparam int MID_SIZE   = TABLE_DEPTH / 2;
  localparam int REL_START  = MID_START + MID_SIZE;
  localparam int REL_SIZE   = TABLE_DEPTH / 4;
  localparam int REL_END_RD = (REL_START + REL_SIZE > TABLE_DEPTH - 1) ?
                              TABLE_DEPTH - 1 : REL_START + REL_SIZE;
  localparam int QW1        = $clog2(MID_SIZE);
  localparam int SIZE_W     = QW1 + 1;
  localparam int PW         = QW1 + DIVR_W;
  localparam logic [IQ_W+1:0] Q_BIAS = {2'b00, 1'b1, {(IQ_W-1){1'b0}}};

  // Captured request.
  action_t           act_r;
  logic [ADDR_W-1:0] addr_r;
  logic [VAL_W-1:0]  val_r;

  // Configuration and playback state.
  logic [LEN_W-1:0] attack_len, middle_len, release_len;
  logic             table_ready;
  phase_t           phase_r;
  logic [LEN_W-1:0] count_r;

  // Section decode.
  logic [LEN_W-1:0]  sec_len;
  logic [SIZE_W-1:0] sec_size;
  logic [AW-1:0]     sec_start, sec_last, sec_end_rd;
  phase_t            sec_next;
  tick_kind_t        kind;

  // Working registers.
  logic [LEN_W-1:0]          len_r;
  logic [PW-1:0]             prod_r;
  logic [AW-1:0]             base_r, last_r, idx_r;
  logic [DIVR_W-1:0]         rem_r, dvsr_r;
  logic [IQ_W-1:0]           low_r, quo_r;
  logic [DCNT_W-1:0]         dcnt_r;
  logic [LEN_W-1:0]          r_r;
  logic [VAL_W-1:0]          v1_r, y_r;
  logic signed [P2_W-1:0]    p2_r;

  // Combinational helpers.
  logic [DIVR_W:0]        rem_sh, rem_sub;
  logic                   rem_ge;
  logic [N2_W-1:0]        num2;
  logic signed [DIFF_W-1:0] diff;
  logic signed [LEN_W:0]  r_s;
  logic [IQ_W+1:0]        y_sum;
  logic [AW-1:0]          idx1, idx2;
  logic [AW:0]            idx_inc;

  // Table memory.
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  wep_ram #(
    .WIDTH(VAL_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(addr_r)),
    .wdata(val_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_len  <= '0;
      middle_len  <= '0;
      release_len <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK:  attack_len  <= cfg_data;
        CFG_MIDDLE:  middle_len  <= cfg_data;
        CFG_RELEASE: release_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // Section parameters of the current phase.
  always_comb begin
    case (phase_r)
      PH_ATTACK: begin
        sec_len    = attack_len;
        sec_size   = SIZE_W'(ATT_SIZE);
        sec_start  = '0;
        sec_last   = AW'(ATT_SIZE - 1);
        sec_end_rd = AW'(ATT_SIZE);
        sec_next   = PH_MIDDLE;
      end
      PH_MIDDLE: begin
        sec_len    = middle_len;
        sec_size   = SIZE_W'(MID_SIZE);
        sec_start  = AW'(MID_START);
        sec_last   = AW'(REL_START - 1);
        sec_end_rd = AW'(REL_START);
        sec_next   = PH_RELEASE;
      end
      PH_RELEASE: begin
        sec_len    = release_len;
        sec_size   = SIZE_W'(REL_SIZE);
        sec_start  = AW'(REL_START);
        sec_last   = AW'(TABLE_DEPTH - 1);
        sec_end_rd = AW'(REL_END_RD);
        sec_next   = PH_IDLE;
      end
      default: begin
        sec_len    = '0;
        sec_size   = '0;
        sec_start  = '0;
        sec_last   = '0;
        sec_end_rd = '0;
        sec_next   = PH_IDLE;
      end
    endcase
  end

  // Decode the captured request.
  always_comb begin
    if (act_r != ACT_TICK) begin
      kind = TK_NONE;
    end else if (phase_r == PH_IDLE) begin
      kind = TK_IDLE;
    end else if (count_r >= sec_len) begin
      kind = TK_END;
    end else begin
      kind = TK_INTERP;
    end
  end

  assign status.kind     = kind;
  assign status.div_busy = (dcnt_r != '0);

  // Table write; addresses past the table are dropped.
  assign ram_we = cmd.exec && (act_r == ACT_WRITE) &&
                  ({{(32-ADDR_W){1'b0}}, addr_r} < 32'(TABLE_DEPTH));

  // Read addresses: left interpolation point, right point clamped to the
  // section's last entry, otherwise the section-end entry.
  assign idx1    = base_r + AW'(quo_r[QW1-1:0]);
  assign idx_inc = {1'b0, idx_r} + 1'b1;
  assign idx2    = (idx_inc > {1'b0, last_r}) ? last_r : idx_inc[AW-1:0];

  always_comb begin
    if (cmd.rd1) begin
      ram_raddr = idx1;
    end else if (cmd.rd2) begin
      ram_raddr = idx2;
    end else begin
      ram_raddr = sec_end_rd;
    end
  end

  // One restoring division step.
  assign rem_sh  = {rem_r, low_r[IQ_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dvsr_r});
  assign rem_sub = rem_sh - {1'b0, dvsr_r};

  // Rounding numerator 2*d*r + L, biased by L * 2^IQ_W to stay positive.
  assign num2 = {p2_r[P2_W-1], p2_r, 1'b0}
              + {{(N2_W-LEN_W){1'b0}}, len_r}
              + {{(N2_W-LEN_W-IQ_W){1'b0}}, len_r, {IQ_W{1'b0}}};

  // Difference of the two table points and the sample result.
  assign diff  = $signed({ram_rdata[VAL_W-1], ram_rdata}) -
                 $signed({v1_r[VAL_W-1], v1_r});
  assign r_s   = $signed({1'b0, r_r});
  assign y_sum = {{(IQ_W+2-VAL_W){v1_r[VAL_W-1]}}, v1_r} + {2'b00, quo_r} - Q_BIAS;

  // Control state: ready flag, phase and tick count.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_ready <= 1'b0;
      phase_r     <= PH_IDLE;
      count_r     <= '0;
    end else if (cmd.exec) begin
      case (act_r)
        ACT_TRIGGER: begin
          if (table_ready) begin
            phase_r <= PH_ATTACK;
            count_r <= '0;
          end
        end
        ACT_READY: table_ready <= 1'b1;
        ACT_TICK: begin
          if (kind == TK_END) begin
            phase_r <= sec_next;
            count_r <= '0;
          end else if (kind == TK_INTERP) begin
            count_r <= count_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= action_t'(action);
      addr_r <= entry_address;
      val_r  <= entry_value;
    end
    if (cmd.exec) begin
      if (kind == TK_IDLE) begin
        y_r <= '0;
      end
      len_r  <= sec_len;
      prod_r <= sec_size * count_r;
      base_r <= sec_start;
      last_r <= sec_last;
    end
    if (cmd.end_cap) begin
      y_r <= ram_rdata;
    end
    if (cmd.div1_load) begin
      rem_r  <= prod_r[PW-1:QW1];
      dvsr_r <= {1'b0, len_r};
      low_r  <= {prod_r[QW1-1:0], {(IQ_W-QW1){1'b0}}};
      quo_r  <= '0;
      dcnt_r <= DCNT_W'(QW1);
    end else if (cmd.div2_load) begin
      rem_r  <= num2[N2_W-2:IQ_W];
      dvsr_r <= {len_r, 1'b0};
      low_r  <= num2[IQ_W-1:0];
      quo_r  <= '0;
      dcnt_r <= DCNT_W'(IQ_W);
    end else if (cmd.div_step) begin
      rem_r  <= rem_ge ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
      low_r  <= {low_r[IQ_W-2:0], 1'b0};
      quo_r  <= {quo_r[IQ_W-2:0], rem_ge};
      dcnt_r <= dcnt_r - 1'b1;
    end
    if (cmd.rd1) begin
      r_r   <= rem_r[LEN_W-1:0];
      idx_r <= idx1;
    end
    if (cmd.rd2) begin
      v1_r <= ram_rdata;
    end
    if (cmd.mul) begin
      p2_r <= diff * r_s;
    end
    if (cmd.fin) begin
      y_r <= y_sum[VAL_W-1:0];
    end
    if (cmd.out_load) begin
      envelope_value <= y_r;
      phase_now      <= phase_r;
    end
  end

endmodule

>>> sv/wep_checker.sv
// Port-level checks for the wavetable envelope player, bound to the top.
// Depends on wep_pkg and wavetable_envelope_player_top.
module wep_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [wep_pkg::VAL_W-1:0] envelope_value,
  input logic [1:0]                       phase_now
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(envelope_value) && $stable(phase_now))
    else $error("result payload changed while stalled");

  // After reset the block is empty and takes requests.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // A request is being worked on in the cycle after it is taken.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken without a busy cycle");

  // No result can appear in the cycle right after a request is taken.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind wavetable_envelope_player_top wep_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .envelope_value(envelope_value),
  .phase_now     (phase_now)
);

>>> tb/sv/wavetable_envelope_player_checker.sv
// Checker for the wavetable envelope player: watches the request, result and
// register write ports, predicts every sample and compares it field by field.
// Depends on wep_pkg.
module wavetable_envelope_player_checker #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [wep_pkg::ACT_W-1:0]         action,
  input  logic [wep_pkg::ADDR_W-1:0]        entry_address,
  input  logic signed [wep_pkg::VAL_W-1:0]  entry_value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [wep_pkg::VAL_W-1:0]  envelope_value,
  input  logic [1:0]                        phase_now,
  input  logic                              cfg_we,
  input  logic [wep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wep_pkg::LEN_W-1:0]         cfg_data,
  output int                                fail_count,
  output int                                outstanding
);
  import wep_pkg::*;

  // Table sections: attack is the first quarter, middle the next half.
  localparam int ATT_SIZE  = TABLE_DEPTH / 4;
  localparam int MID_START = ATT_SIZE;
  localparam int MID_SIZE  = TABLE_DEPTH / 2;
  localparam int REL_START = MID_START + MID_SIZE;
  localparam int REL_SIZE  = TABLE_DEPTH / 4;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    phase_t                  ph;
  } sample_t;

  sample_t expected_samples[$];

  // Predicted copy of the block's state and lengths.
  logic signed [VAL_W-1:0] table_mem [TABLE_DEPTH];
  logic                    ready_flag;
  phase_t                  play_phase;
  logic [LEN_W-1:0]        play_count;
  logic [LEN_W-1:0]        len_attack;
  logic [LEN_W-1:0]        len_middle;
  logic [LEN_W-1:0]        len_release;

  // Reads past the table land on the last entry.
  function automatic longint entry_at(longint idx);
    if (idx > TABLE_DEPTH - 1) idx = TABLE_DEPTH - 1;
    return longint'(table_mem[idx]);
  endfunction

  function automatic longint floor_quot(longint num, longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  // One tick inside a section: interpolate between the entry at the scaled
  // position and its neighbor, or read the section end and move on once the
  // count has reached the length.
  function automatic logic signed [VAL_W-1:0] advance_section(
    longint base, longint span, longint last, logic [LEN_W-1:0] len, phase_t next_phase);
    longint prod;
    longint pos;
    longint rem;
    longint idx;
    longint idx_next;
    longint lo;
    longint hi;
    if (play_count >= len) begin
      play_phase = next_phase;
      play_count = '0;
      return VAL_W'(entry_at(base + span));
    end
    prod = span * longint'(play_count);
    pos  = prod / longint'(len);
    rem  = prod % longint'(len);
    play_count = play_count + 1'b1;
    idx = base + pos;
    idx_next = (idx + 1 > last) ? last : idx + 1;
    lo = entry_at(idx);
    hi = entry_at(idx_next);
    // Round to nearest, ties upward.
    return VAL_W'(lo + floor_quot(2 * (hi - lo) * rem + longint'(len), 2 * longint'(len)));
  endfunction

  always @(posedge clk) begin : watch
    sample_t want;
    if (rst) begin
      ready_flag  = 1'b0;
      play_phase  = PH_IDLE;
      play_count  = '0;
      len_attack  = '0;
      len_middle  = '0;
      len_release = '0;
      expected_samples.delete();
    end else begin
      // Length writes only come while the block has nothing in flight.
      if (cfg_we) begin
        case (cfg_index)
          CFG_ATTACK:  len_attack  = cfg_data;
          CFG_MIDDLE:  len_middle  = cfg_data;
          CFG_RELEASE: len_release = cfg_data;
          default: ;
        endcase
      end

      // A delivered sample is matched against the oldest prediction.
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $error("sample %0d with phase %0d arrived with nothing expected",
                 envelope_value, phase_now);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (envelope_value !== want.value) begin
            $error("envelope_value expected %0d actual %0d", want.value, envelope_value);
            fail_count++;
          end
          if (phase_now !== want.ph) begin
            $error("phase_now expected %0d actual %0d", want.ph, phase_now);
            fail_count++;
          end
        end
      end

      // An accepted request updates the predicted state; a tick adds a sample.
      if (in_valid && !in_stall) begin
        case (action_t'(action))
          ACT_TRIGGER: begin
            if (ready_flag) begin
              play_phase = PH_ATTACK;
              play_count = '0;
            end
          end
          ACT_WRITE: begin
            if (entry_address < TABLE_DEPTH) table_mem[entry_address] = entry_value;
          end
          ACT_READY: ready_flag = 1'b1;
          ACT_TICK: begin
            case (play_phase)
              PH_ATTACK:
                want.value = advance_section(0, ATT_SIZE, ATT_SIZE - 1, len_attack, PH_MIDDLE);
              PH_MIDDLE:
                want.value = advance_section(MID_START, MID_SIZE, MID_START + MID_SIZE - 1,
                                             len_middle, PH_RELEASE);
              PH_RELEASE:
                want.value = advance_section(REL_START, REL_SIZE, TABLE_DEPTH - 1,
                                             len_release, PH_IDLE);
              default: want.value = '0;
            endcase
            want.ph = play_phase;
            expected_samples.push_back(want);
          end
          default: ;
        endcase
      end
    end
    outstanding <= expected_samples.size();
  end

endmodule

>>> tb/sv/wavetable_envelope_player_top_test.sv
// Testbench top for the wavetable envelope player: resets the block, loads the
// table, drives directed and random requests and lengths, and gives the verdict.
// Depends on wep_pkg, wavetable_envelope_player_top and the envelope checker.
module wavetable_envelope_player_top_test;
  import wep_pkg::*;

  localparam int TABLE_DEPTH      = 512;
  localparam int ITEM_TARGET      = 1250;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 8;
  localparam int DRAIN_CYCLES     = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [LEN_W-1:0]     LEN_MAX    = '1;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [ACT_W-1:0]         action;
  logic [ADDR_W-1:0]        entry_address;
  logic signed [VAL_W-1:0]  entry_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [VAL_W-1:0]  envelope_value;
  logic [1:0]               phase_now;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [LEN_W-1:0]         cfg_data;

  int fail_count;
  int outstanding;
  int requests_sent = 0;
  int tx_max_gap = 3;
  int rx_max_hold = 3;
  int idle_cycles = 0;
  bit long_hold_pending = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wavetable_envelope_player_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .entry_address(entry_address),
    .entry_value(entry_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .envelope_value(envelope_value),
    .phase_now(phase_now),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  wavetable_envelope_player_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) envelope_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .entry_address(entry_address),
    .entry_value(entry_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .envelope_value(envelope_value),
    .phase_now(phase_now),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  // Offer one request after a random gap and hold it until it is taken.
  task automatic send_request(action_t act, logic [ADDR_W-1:0] addr, logic [VAL_W-1:0] val);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    entry_address <= addr;
    entry_value   <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_tick();
    send_request(ACT_TICK, ADDR_W'($urandom), VAL_W'($urandom));
  endtask

  // Stop offering, let every sample arrive, then let a non-tick request finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three lengths on consecutive cycles, optionally the unused index too.
  task automatic program_lengths(logic [LEN_W-1:0] att, logic [LEN_W-1:0] mid,
                                 logic [LEN_W-1:0] rel, bit with_unused);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ATTACK;
    cfg_data  <= att;
    @(posedge clk);
    cfg_index <= CFG_MIDDLE;
    cfg_data  <= mid;
    @(posedge clk);
    cfg_index <= CFG_RELEASE;
    cfg_data  <= rel;
    @(posedge clk);
    if (with_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_data  <= LEN_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Result side: a random hold before each sample, and one long hold on request
  // so that the block fills up and stalls its input.
  initial begin : result_sink
    int hold;
    forever begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        hold = LONG_HOLD_CYCLES;
      end else begin
        hold = $urandom_range(0, rx_max_hold);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Watchdog: too long without any request, sample or write means a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("wavetable_envelope_player_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [VAL_W-1:0] v;
    logic [LEN_W-1:0] lens [3];
    int plan;
    int n_ticks;
    int round;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    action        <= ACT_TICK;
    entry_address <= '0;
    entry_value   <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_ATTACK;
    cfg_data      <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Before the table is marked ready: idle ticks and a trigger that is ignored.
    send_tick();
    send_request(ACT_TRIGGER, '0, '0);
    send_tick();

    // Fill the whole table; extremes sit next to each other and at section ends.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      case (i)
        0, 2, 129, 384:                v = 16'h8000;
        1, 128, 383, TABLE_DEPTH - 1:  v = 16'h7FFF;
        default:                       v = VAL_W'($urandom);
      endcase
      send_request(ACT_WRITE, ADDR_W'(i), v);
    end
    send_request(ACT_READY, '0, '0);

    // Lengths are still zero from reset: every phase ends on its first tick,
    // and the release end read is clamped to the last entry.
    send_request(ACT_TRIGGER, '0, '0);
    repeat (4) send_tick();

    // Short lengths, a table write while playing and a restart mid-attack.
    wait_idle();
    program_lengths(12, 2, 1, 1'b1);
    send_request(ACT_TRIGGER, '0, '0);
    repeat (3) send_tick();
    send_request(ACT_WRITE, 9'd11, 16'h7FFF);
    send_tick();
    send_request(ACT_TRIGGER, '0, '0);
    repeat (8) send_tick();

    // Attack shrinks below the count already reached, so the next tick ends it;
    // then the rest of the envelope plays out to idle.
    wait_idle();
    program_lengths(3, 2, 1, 1'b0);
    repeat (7) send_tick();

    // Longest lengths: the position barely moves and the remainder is large.
    wait_idle();
    program_lengths(LEN_MAX, LEN_MAX, LEN_MAX, 1'b0);
    send_request(ACT_TRIGGER, '0, '0);
    repeat (3) send_tick();

    // Random rounds: new lengths, usually a trigger, then a run of ticks with
    // an occasional request of any kind mixed in.
    round = 0;
    while (requests_sent < ITEM_TARGET) begin
      wait_idle();
      plan = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
        if (plan < 6) lens[k] = LEN_W'($urandom_range(0, 12));
        else if (plan < 8) lens[k] = LEN_W'($urandom_range(0, 300));
        else if (plan == 8) lens[k] = LEN_W'($urandom);
        else lens[k] = LEN_MAX - LEN_W'($urandom_range(0, 1));
      end
      program_lengths(lens[0], lens[1], lens[2], $urandom_range(0, 3) == 0);
      tx_max_gap  = ($urandom_range(0, 3) == 0) ? 0 : 3;
      rx_max_hold = ($urandom_range(0, 3) == 0) ? 0 : 3;
      if (plan < 6) n_ticks = int'(lens[0]) + int'(lens[1]) + int'(lens[2]) + $urandom_range(2, 6);
      else n_ticks = $urandom_range(20, 48);
      if (round == 2 || round == 9) begin
        long_hold_pending = 1'b1;
        n_ticks += 30;
      end
      if ($urandom_range(0, 3) != 0)
        send_request(ACT_TRIGGER, ADDR_W'($urandom), VAL_W'($urandom));
      for (int t = 0; t < n_ticks; t++) begin
        if ($urandom_range(0, 11) == 0)
          send_request(action_t'($urandom_range(0, 3)), ADDR_W'($urandom), VAL_W'($urandom));
        else
          send_tick();
      end
      round++;
    end

    // Drain everything still in flight, then give the verdict.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("wavetable_envelope_player_top verification clean");
    else
      $display("wavetable_envelope_player_top verification failed");
    $finish;
  end

endmodule
